[hdl/gpc_pkg.sv]
`timescale 1ns / 1ps
// gpc_pkg: shared types and constants for the ground-plane contact force block.
// No dependencies.
package gpc_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [1:0] {
        CFG_PLANE_HEIGHT  = 2'd0,
        CFG_LOCKING_SPEED = 2'd1,
        CFG_STIFFNESS     = 2'd2,
        CFG_DAMPING       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]         body;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] lz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } pass_t;

    typedef struct packed {
        pass_t              pass;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [17:0]        mu;
        logic [31:0]        depth;
    } item_t;

    typedef struct packed {
        logic        push;
        logic        full;
    } q_ctl_t;

    typedef struct packed {
        logic [32:0] f;
        logic [31:0] ax;
        logic [31:0] az;
        logic        posx;
        logic        posz;
    } side_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] q;
        logic [31:0] low;
        logic        sat;
    } div_t;

endpackage

[hdl/gpc_front.sv]
`timescale 1ns / 1ps
// gpc_front: accepts a vertex, tests it against the ground plane, forwards contacts.
// Depends on gpc_pkg.
module gpc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [7:0]           body_id,
    input  logic signed [31:0]   local_x,
    input  logic signed [31:0]   local_y,
    input  logic signed [31:0]   local_z,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic signed [31:0]   vel_x,
    input  logic signed [31:0]   vel_y,
    input  logic signed [31:0]   vel_z,
    input  logic [17:0]          friction_coef,
    input  logic signed [31:0]   plane_height,
    input  logic                 q_full,
    output logic                 busy,
    output gpc_pkg::q_ctl_t      ctl,
    output gpc_pkg::item_t       item
);
    logic           push_reg, push_next;
    gpc_pkg::item_t item_reg, item_next;
    logic [32:0]    depth_w;

    assign busy    = q_full;
    assign depth_w = {plane_height[31], plane_height} - {pos_y[31], pos_y};

    always_comb
    begin
        push_next            = start && !q_full && (pos_y <= plane_height);
        item_next.pass.body  = body_id;
        item_next.pass.lx    = local_x;
        item_next.pass.ly    = local_y;
        item_next.pass.lz    = local_z;
        item_next.pass.px    = pos_x;
        item_next.pass.py    = pos_y;
        item_next.pass.pz    = pos_z;
        item_next.vx         = vel_x;
        item_next.vy         = vel_y;
        item_next.vz         = vel_z;
        item_next.mu         = friction_coef;
        item_next.depth      = depth_w[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            push_reg <= 1'b0;
        else
            push_reg <= push_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign ctl.push = push_reg;
    assign ctl.full = q_full;
    assign item     = item_reg;
endmodule

[hdl/gpc_fifo.sv]
`timescale 1ns / 1ps
// gpc_fifo: short queue between front and back; drains one entry per cycle.
// Depends on gpc_pkg.
module gpc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  gpc_pkg::q_ctl_t ctl,
    input  gpc_pkg::item_t  wr_item,
    output logic            full,
    output logic            rd_valid,
    output gpc_pkg::item_t  rd_item
);
    gpc_pkg::item_t mem [gpc_pkg::FIFO_DEPTH];
    logic [gpc_pkg::FIFO_AW-1:0] wptr_reg, rptr_reg;
    logic [gpc_pkg::FIFO_AW:0]   cnt_reg, cnt_next;
    logic                        pop, valid_reg;
    gpc_pkg::item_t              data_reg;

    assign pop  = (cnt_reg != '0);
    // one slot kept for the item held in the front register
    assign full = (cnt_reg >= (gpc_pkg::FIFO_AW+1)'(gpc_pkg::FIFO_DEPTH - 1));

    always_comb
    begin
        cnt_next = cnt_reg + (gpc_pkg::FIFO_AW+1)'(ctl.push) - (gpc_pkg::FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg   <= cnt_next;
            valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[wptr_reg] <= wr_item;
        if (pop)
            data_reg <= mem[rptr_reg];
    end

    assign rd_valid = valid_reg;
    assign rd_item  = data_reg;
endmodule

[hdl/gpc_back.sv]
`timescale 1ns / 1ps
// gpc_back: pipelined force datapath (normal force, friction, sqrt, division).
// Depends on gpc_pkg.
module gpc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  gpc_pkg::item_t      in_item,
    input  logic [30:0]         locking_speed,
    input  logic [31:0]         stiffness,
    input  logic [31:0]         damping,
    output logic                out_valid,
    output gpc_pkg::pass_t      out_pass,
    output logic signed [31:0]  force_x,
    output logic signed [31:0]  force_y,
    output logic signed [31:0]  force_z
);
    localparam int LAT = 70;

    logic           vld_reg [LAT];
    gpc_pkg::pass_t pass_reg [LAT];

    // stage 0
    logic [63:0] p0_reg, q0_reg, ax2_reg, az2_reg;
    logic        vyneg0_reg;
    logic [31:0] ax0_reg, az0_reg;
    logic        posx0_reg, posz0_reg;
    logic [17:0] mu0_reg;
    logic [31:0] ax_w, az_w, ay_w;

    assign ax_w = in_item.vx[31] ? 32'(-in_item.vx) : in_item.vx;
    assign az_w = in_item.vz[31] ? 32'(-in_item.vz) : in_item.vz;
    assign ay_w = in_item.vy[31] ? 32'(-in_item.vy) : in_item.vy;

    always_ff @(posedge clk)
    begin
        p0_reg     <= 64'(stiffness) * 64'(in_item.depth);
        q0_reg     <= 64'(damping) * 64'(ay_w);
        ax2_reg    <= 64'(ax_w) * 64'(ax_w);
        az2_reg    <= 64'(az_w) * 64'(az_w);
        vyneg0_reg <= in_item.vy[31];
        ax0_reg    <= ax_w;
        az0_reg    <= az_w;
        posx0_reg  <= (in_item.vx > 0);
        posz0_reg  <= (in_item.vz > 0);
        mu0_reg    <= in_item.mu;
    end

    // stage 1: normal force
    logic [30:0] n1_reg, n1_next;
    logic [63:0] s1_reg;
    logic [17:0] mu1_reg;
    logic [31:0] ax1_reg, az1_reg;
    logic        posx1_reg, posz1_reg;
    logic [64:0] sum_w;
    logic [63:0] dif_w;

    assign sum_w = {1'b0, p0_reg} + {1'b0, q0_reg};
    assign dif_w = p0_reg - q0_reg;

    always_comb
    begin
        priority if (!vyneg0_reg)
        begin
            if (p0_reg <= q0_reg)
                n1_next = '0;
            else if (dif_w[63:47] != '0)
                n1_next = '1;
            else
                n1_next = dif_w[46:16];
        end
        else if (sum_w[64] || (sum_w[63:47] != '0))
            n1_next = '1;
        else
            n1_next = sum_w[46:16];
    end

    always_ff @(posedge clk)
    begin
        n1_reg    <= n1_next;
        s1_reg    <= ax2_reg + az2_reg;
        mu1_reg   <= mu0_reg;
        ax1_reg   <= ax0_reg;
        az1_reg   <= az0_reg;
        posx1_reg <= posx0_reg;
        posz1_reg <= posz0_reg;
    end

    // stage 2: friction magnitude, sqrt setup; stages 3..34: one root bit each
    logic [30:0]    nf_reg;
    logic [48:0]    fprod_w;
    gpc_pkg::side_t side_reg [33];
    logic [33:0]    rem_reg  [33];
    logic [31:0]    root_reg [33];
    logic [63:0]    xs_reg   [33];

    assign fprod_w = 49'(mu1_reg) * 49'(n1_reg);

    always_ff @(posedge clk)
    begin
        side_reg[0].f    <= fprod_w[48:16];
        side_reg[0].ax   <= ax1_reg;
        side_reg[0].az   <= az1_reg;
        side_reg[0].posx <= posx1_reg;
        side_reg[0].posz <= posz1_reg;
        rem_reg[0]       <= '0;
        root_reg[0]      <= '0;
        xs_reg[0]        <= s1_reg;
    end

    for (genvar j = 0; j < 32; j++)
    begin : g_sqrt
        logic [35:0] remsh_w, trial_w;
        assign remsh_w = {rem_reg[j], xs_reg[j][63:62]};
        assign trial_w = {2'b00, root_reg[j], 2'b01};
        always_ff @(posedge clk)
        begin
            side_reg[j+1] <= side_reg[j];
            xs_reg[j+1]   <= {xs_reg[j][61:0], 2'b00};
            if (remsh_w >= trial_w)
            begin
                rem_reg[j+1]  <= 34'(remsh_w - trial_w);
                root_reg[j+1] <= {root_reg[j][30:0], 1'b1};
            end
            else
            begin
                rem_reg[j+1]  <= remsh_w[33:0];
                root_reg[j+1] <= {root_reg[j][30:0], 1'b0};
            end
        end
    end

    // stage 35: divisor; stage 36: numerators
    logic [31:0]    d35_reg;
    gpc_pkg::side_t s35_reg;
    logic [63:0]    numx_w, numz_w;
    gpc_pkg::div_t  divx_reg [33];
    gpc_pkg::div_t  divz_reg [33];
    logic [31:0]    dd_reg   [33];
    logic           dz_reg   [33];
    logic           px_reg   [33];
    logic           pz_reg   [33];

    always_ff @(posedge clk)
    begin
        d35_reg <= (root_reg[32] < {1'b0, locking_speed}) ? {1'b0, locking_speed}
                                                          : root_reg[32];
        s35_reg <= side_reg[32];
    end

    assign numx_w = 64'(s35_reg.f) * 64'(s35_reg.ax);
    assign numz_w = 64'(s35_reg.f) * 64'(s35_reg.az);

    always_ff @(posedge clk)
    begin
        divx_reg[0].rem <= numx_w[63:32];
        divx_reg[0].low <= numx_w[31:0];
        divx_reg[0].q   <= '0;
        divx_reg[0].sat <= (numx_w[63:32] >= d35_reg);
        divz_reg[0].rem <= numz_w[63:32];
        divz_reg[0].low <= numz_w[31:0];
        divz_reg[0].q   <= '0;
        divz_reg[0].sat <= (numz_w[63:32] >= d35_reg);
        dd_reg[0]       <= d35_reg;
        dz_reg[0]       <= (d35_reg == '0);
        px_reg[0]       <= s35_reg.posx;
        pz_reg[0]       <= s35_reg.posz;
    end

    function automatic gpc_pkg::div_t div_step(gpc_pkg::div_t a, logic [31:0] d);
        gpc_pkg::div_t r;
        logic [32:0]   sh;
        sh    = {a.rem, a.low[31]};
        r     = a;
        r.low = {a.low[30:0], 1'b0};
        if (sh >= {1'b0, d})
        begin
            r.rem = 32'(sh - {1'b0, d});
            r.q   = {a.q[30:0], 1'b1};
        end
        else
        begin
            r.rem = sh[31:0];
            r.q   = {a.q[30:0], 1'b0};
        end
        return r;
    endfunction

    for (genvar k = 0; k < 32; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            divx_reg[k+1] <= div_step(divx_reg[k], dd_reg[k]);
            divz_reg[k+1] <= div_step(divz_reg[k], dd_reg[k]);
            dd_reg[k+1]   <= dd_reg[k];
            dz_reg[k+1]   <= dz_reg[k];
            px_reg[k+1]   <= px_reg[k];
            pz_reg[k+1]   <= pz_reg[k];
        end
    end

    function automatic logic [31:0] fric(gpc_pkg::div_t a, logic pos, logic dz);
        logic [31:0] r;
        if (dz)
            r = '0;
        else if (pos)
            r = (a.sat || (a.q > 32'h8000_0000)) ? 32'h8000_0000 : 32'(-a.q);
        else
            r = (a.sat || a.q[31]) ? 32'h7FFF_FFFF : a.q;
        return r;
    endfunction

    // n travels with the payload to the output stage
    logic [30:0] nd_reg [LAT];

    always_ff @(posedge clk)
    begin
        nd_reg[0] <= '0;
        nd_reg[1] <= '0;
        nd_reg[2] <= n1_reg;
        force_x   <= fric(divx_reg[32], px_reg[32], dz_reg[32]);
        force_z   <= fric(divz_reg[32], pz_reg[32], dz_reg[32]);
        nf_reg    <= nd_reg[LAT-2];
        pass_reg[0] <= in_item.pass;
    end

    for (genvar i = 1; i < LAT; i++)
    begin : g_pass
        always_ff @(posedge clk)
        begin
            pass_reg[i] <= pass_reg[i-1];
        end
        if (i >= 3)
        begin : g_nd
            always_ff @(posedge clk)
            begin
                nd_reg[i] <= nd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_pass  = pass_reg[LAT-1];
    assign force_y   = {1'b0, nf_reg};
endmodule

[hdl/ground_plane_penalty_contact_force_top.sv]
`timescale 1ns / 1ps
// Ground-plane penalty contact force, top level. Depends on gpc_pkg, gpc_front,
// gpc_fifo, gpc_back.
// One vertex accepted per cycle while busy is low.
// Rate set by the fully pipelined back end (32-stage square root, 32-stage divider).
// The result strobe done lasts one cycle; the receiver cannot stall.
// Reset sets configuration registers to defaults and clears control state; payload is not reset.
module ground_plane_penalty_contact_force_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          body_id,
    input  logic signed [31:0]  local_x,
    input  logic signed [31:0]  local_y,
    input  logic signed [31:0]  local_z,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  vel_z,
    input  logic [17:0]         friction_coef,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                done,
    output logic [7:0]          contact_body,
    output logic signed [31:0]  contact_x,
    output logic signed [31:0]  contact_y,
    output logic signed [31:0]  contact_z,
    output logic signed [31:0]  contact_local_x,
    output logic signed [31:0]  contact_local_y,
    output logic signed [31:0]  contact_local_z,
    output logic signed [31:0]  force_x,
    output logic signed [31:0]  force_y,
    output logic signed [31:0]  force_z
);
    logic signed [31:0] plane_reg;
    logic [30:0]        lock_reg;
    logic [31:0]        ks_reg, ds_reg;
    logic               q_full, rd_valid;
    gpc_pkg::q_ctl_t    ctl;
    gpc_pkg::item_t     f_item, rd_item;
    gpc_pkg::pass_t     o_pass;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            lock_reg  <= 31'd3277;
            ks_reg    <= '0;
            ds_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (gpc_pkg::cfg_idx_t'(cfg_index))
                gpc_pkg::CFG_PLANE_HEIGHT:  plane_reg <= cfg_data;
                gpc_pkg::CFG_LOCKING_SPEED: lock_reg  <= cfg_data[30:0];
                gpc_pkg::CFG_STIFFNESS:     ks_reg    <= cfg_data;
                gpc_pkg::CFG_DAMPING:       ds_reg    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    gpc_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start),
        .body_id(body_id), .local_x(local_x), .local_y(local_y), .local_z(local_z),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .friction_coef(friction_coef), .plane_height(plane_reg),
        .q_full(q_full), .busy(busy), .ctl(ctl), .item(f_item)
    );

    gpc_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .wr_item(f_item),
        .full(q_full), .rd_valid(rd_valid), .rd_item(rd_item)
    );

    gpc_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(rd_valid), .in_item(rd_item),
        .locking_speed(lock_reg), .stiffness(ks_reg), .damping(ds_reg),
        .out_valid(done), .out_pass(o_pass),
        .force_x(force_x), .force_y(force_y), .force_z(force_z)
    );

    assign contact_body    = o_pass.body;
    assign contact_x       = o_pass.px;
    assign contact_y       = o_pass.py;
    assign contact_z       = o_pass.pz;
    assign contact_local_x = o_pass.lx;
    assign contact_local_y = o_pass.ly;
    assign contact_local_z = o_pass.lz;
endmodule

[tb/ground_plane_penalty_contact_force_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for ground_plane_penalty_contact_force_top: directed and random contact vertices
// checked against an in-bench fixed-point contact force predictor. Depends on gpc_pkg.
module ground_plane_penalty_contact_force_top_tb;

    localparam int LATENCY = 72;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic [7:0]  body;
        logic [31:0] lx, ly, lz, px, py, pz, vx, vy, vz;
        logic [17:0] mu;
    } vertex_t;

    typedef struct {
        logic [7:0]  body;
        logic [31:0] cx, cy, cz, clx, cly, clz, fx, fy, fz;
    } contact_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [7:0] body_id = '0;
    logic signed [31:0] local_x = '0, local_y = '0, local_z = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic [17:0] friction_coef = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic done;
    logic [7:0] contact_body;
    logic signed [31:0] contact_x, contact_y, contact_z;
    logic signed [31:0] contact_local_x, contact_local_y, contact_local_z;
    logic signed [31:0] force_x, force_y, force_z;

    logic signed [63:0] plane_h;
    logic [63:0] lock_spd, spring_k, damp_k;
    contact_t expected_contacts[$];
    int errors = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;

    always #1 clk = ~clk;

    ground_plane_penalty_contact_force_top dut (.*);

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [31:0] friction_axis(logic [63:0] f, logic signed [63:0] v,
                                                  logic [63:0] d);
        logic [63:0] q;
        if (d == 0) return 0;
        q = (f * mag(v)) / d;
        if (v > 0)
        begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(-q);
        end
        if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
        return q[31:0];
    endfunction

    function automatic bit predict_contact(vertex_t v, output contact_t c);
        logic signed [63:0] py, vx, vy, vz;
        logic [63:0] depth, p, q, n, f, t, d;
        py = signed'(v.py);
        vx = signed'(v.vx);
        vy = signed'(v.vy);
        vz = signed'(v.vz);
        if (py > plane_h) return 0;
        depth = plane_h - py;
        p = spring_k * depth;
        q = damp_k * mag(vy);
        if (vy >= 0) n = (p <= q) ? 0 : (p - q) >> 16;
        else if (p > ~64'd0 - q) n = 64'h7fff_ffff;
        else n = (p + q) >> 16;
        if (n > 64'h7fff_ffff) n = 64'h7fff_ffff;
        f = (64'(v.mu) * n) >> 16;
        t = isqrt(mag(vx) * mag(vx) + mag(vz) * mag(vz));
        d = (t < lock_spd) ? lock_spd : t;
        c.body = v.body;
        c.cx = v.px; c.cy = v.py; c.cz = v.pz;
        c.clx = v.lx; c.cly = v.ly; c.clz = v.lz;
        c.fx = friction_axis(f, vx, d);
        c.fy = n[31:0];
        c.fz = friction_axis(f, vz, d);
        return 1;
    endfunction

    task automatic random_gap();
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_vertex(vertex_t v);
        contact_t c;
        random_gap();
        start <= 1'b1;
        body_id <= v.body;
        local_x <= v.lx; local_y <= v.ly; local_z <= v.lz;
        pos_x <= v.px; pos_y <= v.py; pos_z <= v.pz;
        vel_x <= v.vx; vel_y <= v.vy; vel_z <= v.vz;
        friction_coef <= v.mu;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (predict_contact(v, c)) expected_contacts.push_back(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_contacts.size() != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_reg(gpc_pkg::cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            gpc_pkg::CFG_PLANE_HEIGHT:  plane_h = signed'(data);
            gpc_pkg::CFG_LOCKING_SPEED: lock_spd = data[30:0];
            gpc_pkg::CFG_STIFFNESS:     spring_k = data;
            gpc_pkg::CFG_DAMPING:       damp_k = data;
        endcase
    endtask

    task automatic set_config(logic [31:0] h, logic [31:0] l, logic [31:0] k, logic [31:0] d);
        drain();
        write_reg(gpc_pkg::CFG_PLANE_HEIGHT, h);
        write_reg(gpc_pkg::CFG_LOCKING_SPEED, l);
        write_reg(gpc_pkg::CFG_STIFFNESS, k);
        write_reg(gpc_pkg::CFG_DAMPING, d);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            3: return 32'($signed($urandom_range(0, 400000)) - 200000);
            default: return $urandom;
        endcase
    endfunction

    function automatic vertex_t rand_vertex();
        vertex_t v;
        v.body = $urandom;
        v.lx = $urandom; v.ly = $urandom; v.lz = $urandom;
        v.px = $urandom; v.pz = $urandom;
        v.py = ($urandom_range(0, 3) == 0) ? rand_word() : 32'(plane_h - $urandom_range(0, 300000));
        if ($urandom_range(0, 9) == 0) v.py = plane_h[31:0];
        v.vx = rand_word(); v.vy = rand_word(); v.vz = rand_word();
        if ($urandom_range(0, 9) == 0) v.vx = 0;
        if ($urandom_range(0, 9) == 0) v.vz = 0;
        v.mu = $urandom;
        return v;
    endfunction

    function automatic vertex_t make_vertex(logic [31:0] py, logic [31:0] vx, logic [31:0] vy,
                                            logic [31:0] vz, logic [17:0] mu);
        vertex_t v;
        v.body = $urandom;
        v.lx = $urandom; v.ly = $urandom; v.lz = $urandom;
        v.px = $urandom; v.pz = $urandom;
        v.py = py; v.vx = vx; v.vy = vy; v.vz = vz; v.mu = mu;
        return v;
    endfunction

    task automatic test_directed();
        set_config(32'h0001_0000, 32'd3277, 32'h0010_0000, 32'h0000_8000);
        send_vertex(make_vertex(32'h0002_0000, 32'h0001_0000, 0, 0, 18'h10000));
        send_vertex(make_vertex(32'h0001_0000, 32'h0001_0000, 0, 0, 18'h10000));
        send_vertex(make_vertex(32'h0000_0000, 0, 0, 0, 18'h3ffff));
        send_vertex(make_vertex(32'h0000_0000, 32'd100, 32'hffff_0000, 32'hffff_ff00, 18'h3ffff));
        send_vertex(make_vertex(32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 18'h8000));
        send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 18'h3ffff));
        send_vertex(make_vertex(32'h8000_0000, 32'h0000_0001, 32'h0, 32'hffff_ffff, 18'h0));
        send_vertex(make_vertex(32'h7fff_ffff, 32'h1, 32'h1, 32'h1, 18'h1));
        set_config(32'h7fff_ffff, 32'd0, 32'hffff_ffff, 32'hffff_ffff);
        send_vertex(make_vertex(32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 32'h0, 18'h3ffff));
        send_vertex(make_vertex(32'h8000_0000, 32'hffff_0000, 32'h7fff_ffff, 32'h10, 18'h3ffff));
        send_vertex(make_vertex(32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 18'h3ffff));
        send_vertex(make_vertex(32'h0000_0000, 32'h5, 32'h100, 32'hffff_fffb, 18'h20000));
        set_config(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
        send_vertex(make_vertex(32'h8000_0000, 32'h100, 32'hffff_0000, 32'h100, 18'h3ffff));
        send_vertex(make_vertex(32'h8000_0001, 32'h100, 32'h0, 32'h100, 18'h3ffff));
    endtask

    task automatic test_random(int count, logic [31:0] h, logic [31:0] l, logic [31:0] k,
                               logic [31:0] d);
        set_config(h, l, k, d);
        repeat (count) send_vertex(rand_vertex());
    endtask

    task automatic test_pause_until_empty();
        repeat (20) send_vertex(rand_vertex());
        start <= 1'b0;
        while (expected_contacts.size() != 0) @(posedge clk);
        repeat (20) send_vertex(rand_vertex());
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            if (expected_contacts.size() == 0)
            begin
                $display("%0t: unexpected result, body %0d", $time, contact_body);
                errors++;
            end
            else
            begin
                contact_t e;
                e = expected_contacts.pop_front();
                if (e.body !== contact_body || e.cx !== contact_x || e.cy !== contact_y
                    || e.cz !== contact_z || e.clx !== contact_local_x
                    || e.cly !== contact_local_y || e.clz !== contact_local_z
                    || e.fx !== force_x || e.fy !== force_y || e.fz !== force_z)
                begin
                    $display("%0t: mismatch expected body %0d pos %h %h %h loc %h %h %h f %h %h %h",
                             $time, e.body, e.cx, e.cy, e.cz, e.clx, e.cly, e.clz,
                             e.fx, e.fy, e.fz);
                    $display("%0t:          actual body %0d pos %h %h %h loc %h %h %h f %h %h %h",
                             $time, contact_body, contact_x, contact_y, contact_z,
                             contact_local_x, contact_local_y, contact_local_z,
                             force_x, force_y, force_z);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        plane_h = 0;
        lock_spd = 3277;
        spring_k = 0;
        damp_k = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        repeat (30) send_vertex(rand_vertex());
        test_directed();
        test_random(250, 32'h0, 32'd3277, 32'h0004_0000, 32'h0000_4000);
        test_random(200, $urandom, $urandom, $urandom, $urandom);
        test_pause_until_empty();
        test_random(200, 32'hfff0_0000, 32'd0, 32'hffff_ffff, 32'h0);
        test_random(150, 32'h0000_1000, 32'h7fff_ffff, 32'h0100_0000, 32'hffff_ffff);
        gaps_on = 1'b0;
        test_random(150, 32'h0, 32'h0001_0000, 32'h0020_0000, 32'h0001_0000);
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
